// File: sv/three_zone_text_ring_buffer_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the three-zone text ring buffer
// Clocked concurrent assertions; defining ASSERT_OFF compiles them away.
// ----------------------------------------------------------------------------
`ifndef THREE_ZONE_TEXT_RING_BUFFER_DEFINES_SVH
`define THREE_ZONE_TEXT_RING_BUFFER_DEFINES_SVH

`ifndef ASSERT_OFF
// Assertion that is ignored while reset is asserted.
`define TZ_ASSERT(name, prop, clk, rst_n, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Assertion that is checked in every cycle, reset included.
`define TZ_ASSERT_ALWAYS(name, prop, clk, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TZ_ASSERT(name, prop, clk, rst_n, msg)
`define TZ_ASSERT_ALWAYS(name, prop, clk, msg)
`endif

`endif

// File: sv/tztrb_pkg.sv
// ----------------------------------------------------------------------------
// tztrb_pkg
// Field widths, operation and status codes and shared control types.
// ----------------------------------------------------------------------------
package tztrb_pkg;

  localparam int unsigned OP_W   = 4;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned POS_W  = 10;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned CNT_W  = 11;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND  = 4'd0,
    OP_COMMIT  = 4'd1,
    OP_CLEAR   = 4'd2,
    OP_BKSP    = 4'd3,
    OP_CANCEL  = 4'd4,
    OP_PRINT   = 4'd5,
    OP_RELEASE = 4'd6,
    OP_READ    = 4'd7,
    OP_SHOW    = 4'd8
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  // Decoded access for one beat.
  typedef struct packed {
    status_e status;
    logic    mem_we;
    logic    mem_re;
    logic    data_ok;
    logic    run;
  } ctl_t;

endpackage

// File: sv/tztrb_in_if.sv
// ----------------------------------------------------------------------------
// tztrb_in_if
// Command channel: one operation per beat.
// ----------------------------------------------------------------------------
interface tztrb_in_if;
  import tztrb_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [CHAR_W-1:0] char_in;
  logic [POS_W-1:0]  position;

  modport source (output valid, op, char_in, position, input ready);
  modport sink   (input valid, op, char_in, position, output ready);
endinterface

// File: sv/tztrb_out_if.sv
// ----------------------------------------------------------------------------
// tztrb_out_if
// Result channel: one result per beat.
// ----------------------------------------------------------------------------
interface tztrb_out_if;
  import tztrb_pkg::*;

  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [CHAR_W-1:0] data_out;
  logic              data_valid;
  logic              is_full;
  logic [CNT_W-1:0]  line_count;
  logic [CNT_W-1:0]  queue_count;
  logic [CNT_W-1:0]  editable_count;
  logic              last;

  modport source (output valid, status, data_out, data_valid, is_full, line_count,
                  queue_count, editable_count, last, input ready);
  modport sink   (input valid, status, data_out, data_valid, is_full, line_count,
                  queue_count, editable_count, last, output ready);
endinterface

// File: sv/tztrb_ram.sv
// ----------------------------------------------------------------------------
// tztrb_ram
// Generic single-port RAM with a registered read port.
// ----------------------------------------------------------------------------
module tztrb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/tztrb_zone.sv
// ----------------------------------------------------------------------------
// tztrb_zone
// Zone bookkeeping: start pointer and the three zone lengths, operation
// decode and store address generation.
// ----------------------------------------------------------------------------
module tztrb_zone #(
  parameter int unsigned STORE_DEPTH  = 1024,
  parameter int unsigned SCREEN_WIDTH = 32,
  localparam int unsigned AW    = $clog2(STORE_DEPTH),
  localparam int unsigned LEN_W = $clog2(STORE_DEPTH + 1),
  localparam int unsigned RUN_W = $clog2(SCREEN_WIDTH)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic [tztrb_pkg::OP_W-1:0]  op_i,
  input  logic [tztrb_pkg::CHAR_W-1:0] char_i,
  input  logic [tztrb_pkg::POS_W-1:0] pos_i,
  output tztrb_pkg::ctl_t             ctl_o,
  output logic [AW-1:0]               mem_addr_o,
  output logic [tztrb_pkg::CHAR_W-1:0] wdata_o,
  output logic [RUN_W-1:0]            run_len_o,
  output logic [LEN_W-1:0]            line_len_o,
  output logic [LEN_W-1:0]            queue_len_o,
  output logic [LEN_W-1:0]            edit_len_o,
  output logic                        full_o
);
  import tztrb_pkg::*;

  localparam int unsigned OFF_W = ((LEN_W + 2) > POS_W) ? (LEN_W + 2) : POS_W;
  localparam int unsigned SUM_W = OFF_W + 1;
  localparam int unsigned MAXRUN = SCREEN_WIDTH - 1;

  logic [AW-1:0]    zone_start_q, zone_start_d;
  logic [LEN_W-1:0] line_q, line_d;
  logic [LEN_W-1:0] queue_q, queue_d;
  logic [LEN_W-1:0] edit_q, edit_d;

  logic [OFF_W-1:0] total;
  logic [OFF_W-1:0] base;
  logic [RUN_W-1:0] run_len;
  ctl_t             ctl;
  logic [AW-1:0]    addr;

  // Offset from the zone start to a store address; the sum stays below
  // twice the depth, so one conditional subtract wraps it.
  function automatic logic [AW-1:0] wrap(input logic [AW-1:0] start,
                                         input logic [OFF_W-1:0] offset);
    logic [SUM_W-1:0] s;
    s = SUM_W'(start) + SUM_W'(offset);
    if (s >= SUM_W'(STORE_DEPTH)) begin
      s = s - SUM_W'(STORE_DEPTH);
    end
    return AW'(s);
  endfunction

  assign total = OFF_W'(line_q) + OFF_W'(queue_q) + OFF_W'(edit_q);
  assign full_o = (total >= OFF_W'(STORE_DEPTH));

  // Show window: the newest editable bytes, at most SCREEN_WIDTH-1 of them.
  assign run_len = (OFF_W'(edit_q) > OFF_W'(MAXRUN)) ? RUN_W'(MAXRUN) : RUN_W'(edit_q);
  assign base    = OFF_W'(line_q) + OFF_W'(queue_q) + OFF_W'(edit_q) - OFF_W'(run_len);

  always_comb begin
    ctl  = '{status: ST_OK, mem_we: 1'b0, mem_re: 1'b0, data_ok: 1'b0, run: 1'b0};
    addr = wrap(zone_start_q, total);
    case (op_e'(op_i))
      OP_APPEND: begin
        if (full_o) begin
          ctl.status = ST_FULL;
        end else begin
          ctl.mem_we = 1'b1;
        end
      end
      OP_PRINT: begin
        addr = wrap(zone_start_q, OFF_W'(line_q));
        if (queue_q == '0) begin
          ctl.status = ST_EMPTY;
        end else begin
          ctl.mem_re  = 1'b1;
          ctl.data_ok = 1'b1;
        end
      end
      OP_READ: begin
        addr = wrap(zone_start_q, OFF_W'(pos_i));
        if (OFF_W'(pos_i) >= OFF_W'(line_q)) begin
          ctl.status = ST_RANGE;
        end else begin
          ctl.mem_re  = 1'b1;
          ctl.data_ok = 1'b1;
        end
      end
      OP_SHOW: begin
        addr    = wrap(zone_start_q, base);
        ctl.run = 1'b1;
        if (run_len != '0) begin
          ctl.mem_re  = 1'b1;
          ctl.data_ok = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    zone_start_d = zone_start_q;
    line_d       = line_q;
    queue_d      = queue_q;
    edit_d       = edit_q;
    if (accept_i) begin
      case (op_e'(op_i))
        OP_APPEND: begin
          if (!full_o) begin
            edit_d = edit_q + 1'b1;
          end
        end
        OP_COMMIT: begin
          queue_d = queue_q + edit_q;
          edit_d  = '0;
        end
        OP_CLEAR: begin
          edit_d = '0;
        end
        OP_BKSP: begin
          if (edit_q != '0) begin
            edit_d = edit_q - 1'b1;
          end
        end
        OP_CANCEL: begin
          edit_d  = edit_q + queue_q;
          queue_d = '0;
        end
        OP_PRINT: begin
          if (queue_q != '0) begin
            queue_d = queue_q - 1'b1;
            line_d  = line_q + 1'b1;
          end
        end
        OP_RELEASE: begin
          zone_start_d = wrap(zone_start_q, OFF_W'(line_q));
          line_d       = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zone_start_q <= '0;
      line_q       <= '0;
      queue_q      <= '0;
      edit_q       <= '0;
    end else begin
      zone_start_q <= zone_start_d;
      line_q       <= line_d;
      queue_q      <= queue_d;
      edit_q       <= edit_d;
    end
  end

  assign ctl_o       = ctl;
  assign mem_addr_o  = addr;
  assign wdata_o     = char_i;
  assign run_len_o   = run_len;
  assign line_len_o  = line_q;
  assign queue_len_o = queue_q;
  assign edit_len_o  = edit_q;

endmodule

// File: sv/three_zone_text_ring_buffer.sv
// ----------------------------------------------------------------------------
// three_zone_text_ring_buffer
// Circular text store split into printing line, print queue and editable text.
// ----------------------------------------------------------------------------
// A command's store access is issued at accept and its result beats are
//   registered from S_EMIT; show-editable gives max(n, 1) result beats for
//   n = min(editable bytes, SCREEN_WIDTH-1), one read of the single store port
//   per byte shown.
// Output stalls hold the run; the input waits until the run is out.
// Reset: zones empty, zone start at entry 0; the store is not cleared.
`include "three_zone_text_ring_buffer_defines.svh"

module three_zone_text_ring_buffer #(
  parameter int unsigned STORE_DEPTH  = 1024,
  parameter int unsigned SCREEN_WIDTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tztrb_in_if.sink   in_i,
  tztrb_out_if.source out_o
);
  import tztrb_pkg::*;

  localparam int unsigned AW    = $clog2(STORE_DEPTH);
  localparam int unsigned LEN_W = $clog2(STORE_DEPTH + 1);
  localparam int unsigned RUN_W = $clog2(SCREEN_WIDTH);
  localparam int unsigned TOT_W = LEN_W + 2;

  typedef enum logic {
    S_IDLE,
    S_EMIT
  } state_e;

  state_e           state_q;
  ctl_t             ctl_q;
  logic [RUN_W-1:0] rem_q;     // run beats left after the current one
  logic [AW-1:0]    raddr_q;   // next store address of a show run

  // Output register.
  logic              out_valid_q;
  logic [STAT_W-1:0] out_status_q;
  logic [CHAR_W-1:0] out_data_q;
  logic              out_dvalid_q;
  logic              out_full_q;
  logic [CNT_W-1:0]  out_line_q;
  logic [CNT_W-1:0]  out_queue_q;
  logic [CNT_W-1:0]  out_edit_q;
  logic              out_last_q;

  ctl_t              zctl;
  logic [AW-1:0]     zaddr;
  logic [CHAR_W-1:0] zwdata;
  logic [RUN_W-1:0]  run_len;
  logic [LEN_W-1:0]  line_len, queue_len, edit_len;
  logic              full;

  logic              in_acc;
  logic              slot_free;
  logic              emit;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_addr;
  logic [CHAR_W-1:0] rdata;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign slot_free  = !out_valid_q || out_o.ready;
  assign emit       = (state_q == S_EMIT) && slot_free;

  tztrb_zone #(
    .STORE_DEPTH  (STORE_DEPTH),
    .SCREEN_WIDTH (SCREEN_WIDTH)
  ) u_zone (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_acc),
    .op_i        (in_i.op),
    .char_i      (in_i.char_in),
    .pos_i       (in_i.position),
    .ctl_o       (zctl),
    .mem_addr_o  (zaddr),
    .wdata_o     (zwdata),
    .run_len_o   (run_len),
    .line_len_o  (line_len),
    .queue_len_o (queue_len),
    .edit_len_o  (edit_len),
    .full_o      (full)
  );

  // Store port: the command's own access at accept, run reads while emitting.
  always_comb begin
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    mem_addr = zaddr;
    if (in_acc) begin
      mem_we = zctl.mem_we;
      mem_re = zctl.mem_re;
    end else if (emit && (rem_q != '0)) begin
      mem_re   = 1'b1;
      mem_addr = raddr_q;
    end
  end

  tztrb_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (zwdata),
    .rdata_o (rdata)
  );

  function automatic logic [AW-1:0] next_addr(input logic [AW-1:0] a);
    return (a == AW'(STORE_DEPTH - 1)) ? '0 : AW'(a + 1'b1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      ctl_q        <= '{status: ST_OK, mem_we: 1'b0, mem_re: 1'b0, data_ok: 1'b0,
                        run: 1'b0};
      rem_q        <= '0;
      raddr_q      <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= '0;
      out_data_q   <= '0;
      out_dvalid_q <= 1'b0;
      out_full_q   <= 1'b0;
      out_line_q   <= '0;
      out_queue_q  <= '0;
      out_edit_q   <= '0;
      out_last_q   <= 1'b0;
    end else begin
      // Drop the waiting beat once taken, unless a new one loads below.
      if (out_o.ready && !emit) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            ctl_q   <= zctl;
            raddr_q <= next_addr(zaddr);
            rem_q   <= (zctl.run && zctl.mem_re) ? RUN_W'(run_len - 1'b1) : '0;
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            out_valid_q  <= 1'b1;
            out_status_q <= ctl_q.status;
            out_data_q   <= ctl_q.data_ok ? rdata : '0;
            out_dvalid_q <= ctl_q.data_ok;
            out_full_q   <= full;
            out_line_q   <= CNT_W'(line_len);
            out_queue_q  <= CNT_W'(queue_len);
            out_edit_q   <= CNT_W'(edit_len);
            out_last_q   <= (rem_q == '0);
            if (rem_q != '0) begin
              // Advance the run: the next byte is being read this cycle.
              rem_q   <= rem_q - 1'b1;
              raddr_q <= next_addr(raddr_q);
            end else begin
              state_q <= S_IDLE;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.status         = out_status_q;
  assign out_o.data_out       = out_data_q;
  assign out_o.data_valid     = out_dvalid_q;
  assign out_o.is_full        = out_full_q;
  assign out_o.line_count     = out_line_q;
  assign out_o.queue_count    = out_queue_q;
  assign out_o.editable_count = out_edit_q;
  assign out_o.last           = out_last_q;

  // Zones never overlap: together they fit in the store.
  `TZ_ASSERT(a_zone_bound, (TOT_W'(line_len) + TOT_W'(queue_len) + TOT_W'(edit_len) <= TOT_W'(STORE_DEPTH)), clk_i, rst_ni, "zone lengths exceed store depth")
  // The single store port never writes and reads in one cycle.
  `TZ_ASSERT_ALWAYS(a_port_excl, !(mem_we && mem_re), clk_i, "store write and read together")
  // Counts reported by a run stay fixed while it is emitted.
  `TZ_ASSERT(a_counts_hold, ((state_q == S_EMIT) && $past(state_q == S_EMIT)) |-> ($stable(line_len) && $stable(queue_len) && $stable(edit_len)), clk_i, rst_ni, "zone counts changed while emitting")

endmodule

// File: dv/tb_three_zone_text_ring_buffer.sv
// ----------------------------------------------------------------------------
// tb_three_zone_text_ring_buffer
// Self-checking bench for the three-zone circular text store. A driver feeds
// command beats from a queue; every accepted command runs through a local
// model of the store that queues the result beats it should produce, and a
// monitor compares each result beat field by field against the oldest one.
// Stimulus: a short directed pass over the corner cases, random editing,
// printing and noise sessions, then a closing mix of shows and zone moves.
// ----------------------------------------------------------------------------
module tb_three_zone_text_ring_buffer;
  timeunit 1ns;
  timeprecision 1ps;

  import tztrb_pkg::*;

  localparam int unsigned DEPTH        = 1024;
  localparam int unsigned SCREEN_W     = 32;
  localparam int unsigned RANDOM_ITEMS = 370;
  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned IDLE_PCT     = 32;
  localparam int unsigned MAX_PRINTED  = 60;
  localparam int unsigned DRAIN_CYCLES = 2 * SCREEN_W + 8;
  localparam int          TIMEOUT_NS   = 1_600_000;

  // First unused opcode and the top of the opcode space; both are ignored.
  localparam logic [OP_W-1:0] OP_SPARE = OP_SHOW + 1'b1;
  localparam logic [OP_W-1:0] OP_LAST  = '1;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [CHAR_W-1:0] ch;
    logic [POS_W-1:0]  pos;
    logic              burst;   // beat belongs to the stretch with no idling
  } command_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [CHAR_W-1:0] data;
    logic              data_valid;
    logic              full;
    logic [CNT_W-1:0]  line_cnt;
    logic [CNT_W-1:0]  queue_cnt;
    logic [CNT_W-1:0]  edit_cnt;
    logic              last;
  } result_t;

  logic clk_i;
  logic rst_ni;

  tztrb_in_if  in_if ();
  tztrb_out_if out_if ();

  three_zone_text_ring_buffer #(
    .STORE_DEPTH  (DEPTH),
    .SCREEN_WIDTH (SCREEN_W)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Stimulus and scoreboard storage.
  command_t command_q[$];
  result_t  pending_results[$];

  int unsigned error_count = 0;
  int unsigned result_no   = 0;
  int unsigned stim_count  = 0;
  int unsigned hold_left   = 0;   // receiver hold-off, counted down by the sink
  bit          burst_stim  = 1'b0;
  bit          calm        = 1'b0;
  bit          cmd_taken   = 1'b0;

  // Local copy of the store: byte array plus the three zone lengths.
  logic [CHAR_W-1:0] text_mem [DEPTH];
  int unsigned zone_base = 0;
  int unsigned line_len  = 0;
  int unsigned queue_len = 0;
  int unsigned edit_len  = 0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Map an offset from the zone start onto a store entry.
  function automatic int unsigned slot(input int unsigned off);
    return (zone_base + off) % DEPTH;
  endfunction

  function automatic bit store_full();
    return (line_len + queue_len + edit_len) >= DEPTH;
  endfunction

  // Stamp the post-step occupancy onto a result and queue it.
  task automatic push_result(input result_t r);
    r.full      = store_full();
    r.line_cnt  = line_len[CNT_W-1:0];
    r.queue_cnt = queue_len[CNT_W-1:0];
    r.edit_cnt  = edit_len[CNT_W-1:0];
    pending_results.push_back(r);
  endtask

  // Advance the local store by one command and queue the beats it yields.
  task automatic step_text_store(input command_t c);
    result_t     r;
    int unsigned run;
    int unsigned first;
    r     = '0;
    run   = 0;
    first = 0;
    r.status = ST_OK;
    case (c.op)
      OP_APPEND: begin
        if (store_full()) begin
          r.status = ST_FULL;
        end else begin
          text_mem[slot(line_len + queue_len + edit_len)] = c.ch;
          edit_len++;
        end
      end
      OP_COMMIT: begin
        queue_len += edit_len;
        edit_len = 0;
      end
      OP_CLEAR: begin
        edit_len = 0;
      end
      OP_BKSP: begin
        if (edit_len != 0) edit_len--;
      end
      OP_CANCEL: begin
        edit_len += queue_len;
        queue_len = 0;
      end
      OP_PRINT: begin
        if (queue_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.data       = text_mem[slot(line_len)];
          r.data_valid = 1'b1;
          queue_len--;
          line_len++;
        end
      end
      OP_RELEASE: begin
        zone_base = slot(line_len);
        line_len  = 0;
      end
      OP_READ: begin
        if (c.pos >= line_len) begin
          r.status = ST_RANGE;
        end else begin
          r.data       = text_mem[slot(c.pos)];
          r.data_valid = 1'b1;
        end
      end
      OP_SHOW: begin
        // Tail of the editable zone, oldest byte first, one beat per byte.
        run   = (edit_len < SCREEN_W - 1) ? edit_len : SCREEN_W - 1;
        first = line_len + queue_len + edit_len - run;
        for (int unsigned k = 0; k < run; k++) begin
          r.data       = text_mem[slot(first + k)];
          r.data_valid = 1'b1;
          r.last       = (k + 1 == run);
          push_result(r);
        end
      end
      default: begin
      end
    endcase
    if (run == 0) begin
      r.last = 1'b1;
      push_result(r);
    end
  endtask

  task automatic queue_cmd(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                           input logic [POS_W-1:0] pos);
    command_t c;
    c.op    = op;
    c.ch    = ch;
    c.pos   = pos;
    c.burst = burst_stim;
    command_q.push_back(c);
    if (op <= OP_SHOW) stim_count++;
  endtask

  function automatic logic [CHAR_W-1:0] rnd_char();
    return CHAR_W'($urandom_range(0, (1 << CHAR_W) - 1));
  endfunction

  function automatic logic [POS_W-1:0] rnd_pos();
    return POS_W'($urandom_range(0, (1 << POS_W) - 1));
  endfunction

  // Reads mostly land near the start of the line so that many are in range.
  function automatic logic [POS_W-1:0] near_pos();
    if ($urandom_range(0, 4) == 0) return rnd_pos();
    return POS_W'($urandom_range(0, 40));
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    if (error_count <= MAX_PRINTED)
      $display("%0t: result %0d: %s got %0h expected %0h", $realtime, result_no, what,
               got, want);
  endtask

  // Park after the falling edge and before the rising edge, clear of every update.
  task automatic settle();
    @(negedge clk_i);
    #0.5;
  endtask

  // Hold the sender until every queued command has produced all its beats.
  task automatic wait_drained();
    while (command_q.size() != 0 || in_if.valid || pending_results.size() != 0)
      settle();
  endtask

  // --------------------------------------------------------------------------
  // Command driver: drive at the falling edge. A beat stays on the bus until
  // the rising edge takes it; only then may the next one go up or the bus go
  // idle. Idle gaps are skipped for beats flagged as part of a burst, and the
  // sink follows the flag of the beat on the bus.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_if.valid || cmd_taken) begin
        if (command_q.size() != 0 &&
            (command_q[0].burst || $urandom_range(0, 99) >= IDLE_PCT)) begin
          in_if.op       <= command_q[0].op;
          in_if.char_in  <= command_q[0].ch;
          in_if.position <= command_q[0].pos;
          in_if.valid    <= 1'b1;
          calm           <= command_q[0].burst;
          void'(command_q.pop_front());
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result sink: ready changes at the falling edge. A pending hold-off keeps
  // ready low for its whole count; otherwise stall at random unless the
  // current beat is part of the no-idle stretch.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: sample both channels at the rising edge. An accepted command is
  // run through the model first, so its beats are queued before any result
  // can show up for it. Each accepted result is checked against the oldest
  // expectation; compare with !== so X or Z on an output counts as wrong.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    command_t got_cmd;
    result_t  want;
    if (rst_ni) begin
      cmd_taken = in_if.valid && in_if.ready;
      if (cmd_taken) begin
        got_cmd.op    = in_if.op;
        got_cmd.ch    = in_if.char_in;
        got_cmd.pos   = in_if.position;
        got_cmd.burst = 1'b0;
        step_text_store(got_cmd);
      end
      if (out_if.valid === 1'b1 && out_if.ready) begin
        result_no++;
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected beat", out_if.status, '0);
        end else begin
          want = pending_results.pop_front();
          if (out_if.status !== want.status)
            report_mismatch("status", out_if.status, want.status);
          if (out_if.data_out !== want.data)
            report_mismatch("data_out", out_if.data_out, want.data);
          if (out_if.data_valid !== want.data_valid)
            report_mismatch("data_valid", out_if.data_valid, want.data_valid);
          if (out_if.is_full !== want.full)
            report_mismatch("is_full", out_if.is_full, want.full);
          if (out_if.line_count !== want.line_cnt)
            report_mismatch("line_count", out_if.line_count, want.line_cnt);
          if (out_if.queue_count !== want.queue_cnt)
            report_mismatch("queue_count", out_if.queue_count, want.queue_cnt);
          if (out_if.editable_count !== want.edit_cnt)
            report_mismatch("editable_count", out_if.editable_count, want.edit_cnt);
          if (out_if.last !== want.last)
            report_mismatch("last", out_if.last, want.last);
        end
      end
    end
  end

  // Separate guard so a hung handshake cannot stall the run forever.
  initial begin
    #(TIMEOUT_NS);
    $display("tb_three_zone_text_ring_buffer: errors");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned sessions;
    int unsigned kind;
    int unsigned n;
    int unsigned pick;
    logic [OP_W-1:0] op;

    sessions       = 0;
    rst_ni         = 1'b0;
    in_if.valid    = 1'b0;
    in_if.op       = OP_APPEND;
    in_if.char_in  = '0;
    in_if.position = '0;
    out_if.ready   = 1'b0;

    repeat (9) @(posedge clk_i);
    settle();
    rst_ni = 1'b1;

    // Directed corners on an empty store: empty show, print on an empty
    // queue, read past an empty line, backspace with nothing to erase and
    // both ends of the unused opcode range.
    queue_cmd(OP_SHOW, rnd_char(), rnd_pos());
    queue_cmd(OP_PRINT, rnd_char(), rnd_pos());
    queue_cmd(OP_READ, rnd_char(), '0);
    queue_cmd(OP_BKSP, rnd_char(), rnd_pos());
    queue_cmd(OP_SPARE, '1, '1);
    queue_cmd(OP_LAST, '0, '0);
    // Extreme and alternating bytes, a short show, then edit and commit.
    queue_cmd(OP_APPEND, '0, rnd_pos());
    queue_cmd(OP_APPEND, '1, rnd_pos());
    queue_cmd(OP_APPEND, 8'hA5, rnd_pos());
    queue_cmd(OP_APPEND, 8'h5A, rnd_pos());
    queue_cmd(OP_SHOW, rnd_char(), rnd_pos());
    queue_cmd(OP_BKSP, rnd_char(), rnd_pos());
    queue_cmd(OP_COMMIT, rnd_char(), rnd_pos());
    // Print two bytes, read inside, at the edge of and far past the line.
    queue_cmd(OP_PRINT, rnd_char(), rnd_pos());
    queue_cmd(OP_PRINT, rnd_char(), rnd_pos());
    queue_cmd(OP_READ, rnd_char(), POS_W'(0));
    queue_cmd(OP_READ, rnd_char(), POS_W'(1));
    queue_cmd(OP_READ, rnd_char(), POS_W'(2));
    queue_cmd(OP_READ, rnd_char(), '1);
    // Pull the queue back, drop it, free the line, then no-op zone moves.
    queue_cmd(OP_CANCEL, rnd_char(), rnd_pos());
    queue_cmd(OP_CLEAR, rnd_char(), rnd_pos());
    queue_cmd(OP_RELEASE, rnd_char(), rnd_pos());
    queue_cmd(OP_COMMIT, rnd_char(), rnd_pos());
    queue_cmd(OP_CANCEL, rnd_char(), rnd_pos());
    wait_drained();

    // Hold off the sink while commands keep coming, so the block backs up
    // and has to stall its input.
    hold_left  = HOLD_CYCLES;
    stim_count = 0;

    // Random sessions: mostly well-formed typing and printing with random
    // content, some cancel-and-edit, and a bit of noise across all opcodes.
    while (stim_count < RANDOM_ITEMS) begin
      sessions++;
      burst_stim = (sessions >= 8 && sessions < 14);
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        n = $urandom_range(1, 40);
        for (int unsigned i = 0; i < n; i++) begin
          if ($urandom_range(0, 9) == 0) queue_cmd(OP_BKSP, rnd_char(), rnd_pos());
          else queue_cmd(OP_APPEND, rnd_char(), rnd_pos());
        end
        if ($urandom_range(0, 1) == 0) queue_cmd(OP_SHOW, rnd_char(), rnd_pos());
        pick = $urandom_range(0, 9);
        if (pick < 7) queue_cmd(OP_COMMIT, rnd_char(), rnd_pos());
        else if (pick < 9) queue_cmd(OP_CLEAR, rnd_char(), rnd_pos());
      end else if (kind < 75) begin
        n = $urandom_range(1, 24);
        for (int unsigned i = 0; i < n; i++) queue_cmd(OP_PRINT, rnd_char(), rnd_pos());
        n = $urandom_range(1, 4);
        for (int unsigned i = 0; i < n; i++) queue_cmd(OP_READ, rnd_char(), near_pos());
        if ($urandom_range(0, 2) == 0) queue_cmd(OP_RELEASE, rnd_char(), rnd_pos());
      end else if (kind < 85) begin
        queue_cmd(OP_CANCEL, rnd_char(), rnd_pos());
        n = $urandom_range(0, 3);
        for (int unsigned i = 0; i < n; i++) queue_cmd(OP_BKSP, rnd_char(), rnd_pos());
        queue_cmd(OP_SHOW, rnd_char(), rnd_pos());
        queue_cmd(OP_COMMIT, rnd_char(), rnd_pos());
      end else begin
        n = $urandom_range(1, 4);
        for (int unsigned i = 0; i < n; i++) begin
          op = OP_W'($urandom_range(0, OP_LAST));
          queue_cmd(op, rnd_char(), rnd_pos());
        end
      end
    end
    burst_stim = 1'b0;
    wait_drained();

    // Close with a long show, print and reads around a release, then move
    // the zones around and show what is left.
    queue_cmd(OP_SHOW, rnd_char(), rnd_pos());
    queue_cmd(OP_APPEND, rnd_char(), rnd_pos());
    queue_cmd(OP_PRINT, rnd_char(), rnd_pos());
    queue_cmd(OP_READ, rnd_char(), near_pos());
    queue_cmd(OP_READ, rnd_char(), '1);
    queue_cmd(OP_RELEASE, rnd_char(), rnd_pos());
    queue_cmd(OP_APPEND, rnd_char(), rnd_pos());
    queue_cmd(OP_COMMIT, rnd_char(), rnd_pos());
    queue_cmd(OP_CANCEL, rnd_char(), rnd_pos());
    queue_cmd(OP_SHOW, rnd_char(), rnd_pos());
    queue_cmd(OP_CLEAR, rnd_char(), rnd_pos());
    queue_cmd(OP_SHOW, rnd_char(), rnd_pos());
    wait_drained();

    // Let any stray beats surface before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb_three_zone_text_ring_buffer: clean");
    end else begin
      $display("tb_three_zone_text_ring_buffer: errors");
    end
    $finish;
  end

endmodule
